/* sv/cpuas_pkg.sv */
// Shared types and constants for the add/subtract ALU with flags.
package cpuas_pkg;

    typedef enum logic [2:0] {
        FUNC_ADD       = 3'd0,
        FUNC_ADC       = 3'd1,
        FUNC_SUB       = 3'd2,
        FUNC_SBC       = 3'd3,
        FUNC_PAIR_ADD  = 3'd4,
        FUNC_PAIR_SADD = 3'd5
    } func_t;

    localparam int FLAG_Z = 3;
    localparam int FLAG_N = 2;
    localparam int FLAG_H = 1;
    localparam int FLAG_C = 0;

    typedef struct packed {
        logic        wr_en;
        logic [15:0] wr_data;
        logic [15:0] result;
        logic [3:0]  flags;
    } alu_res_t;

endpackage

/* sv/cpuas_ram.sv */
// Generic RAM, one write port and two registered read ports.
module cpuas_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_a_reg <= mem_reg[raddr_a];
            rdata_b_reg <= mem_reg[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

/* sv/cpuas_alu.sv */
// Byte and pair add/subtract datapath with flag generation.
module cpuas_alu
    import cpuas_pkg::*;
(
    input  logic [2:0]  func,
    input  logic [2:0]  dst_index,
    input  logic [2:0]  src_index,
    input  logic        src_is_operand,
    input  logic [7:0]  operand,
    input  logic [15:0] dst_pair,
    input  logic [15:0] src_pair,
    input  logic [3:0]  flags_in,
    output alu_res_t    res
);

    logic [7:0]  a_byte;
    logic [7:0]  b_byte;
    logic        cin;
    logic [8:0]  sum9;
    logic [4:0]  sum5;
    logic [8:0]  dif9;
    logic [4:0]  dif5;
    logic [7:0]  byte_res;
    logic [16:0] sum17;
    logic [12:0] sum13;
    logic [15:0] sadd;
    logic [4:0]  sadd_h;
    logic [8:0]  sadd_c;
    logic [15:0] byte_wr;

    always_comb begin
        a_byte = dst_index[0] ? dst_pair[7:0] : dst_pair[15:8];
        b_byte = src_is_operand ? operand
               : (src_index[0] ? src_pair[7:0] : src_pair[15:8]);
        cin    = (func == FUNC_ADC || func == FUNC_SBC) ? flags_in[FLAG_C] : 1'b0;
        sum9   = {1'b0, a_byte} + {1'b0, b_byte} + 9'(cin);
        sum5   = {1'b0, a_byte[3:0]} + {1'b0, b_byte[3:0]} + 5'(cin);
        dif9   = {1'b0, a_byte} - {1'b0, b_byte} - 9'(cin);
        dif5   = {1'b0, a_byte[3:0]} - {1'b0, b_byte[3:0]} - 5'(cin);
        sum17  = {1'b0, dst_pair} + {1'b0, src_pair};
        sum13  = {1'b0, dst_pair[11:0]} + {1'b0, src_pair[11:0]};
        sadd   = dst_pair + {{8{operand[7]}}, operand};
        sadd_h = {1'b0, dst_pair[3:0]} + {1'b0, operand[3:0]};
        sadd_c = {1'b0, dst_pair[7:0]} + {1'b0, operand};
        byte_res = (func == FUNC_ADD || func == FUNC_ADC) ? sum9[7:0] : dif9[7:0];
        byte_wr  = dst_index[0] ? {dst_pair[15:8], byte_res} : {byte_res, dst_pair[7:0]};

        res = '0;
        unique case (func)
            FUNC_ADD, FUNC_ADC: begin
                res.wr_en          = 1'b1;
                res.wr_data        = byte_wr;
                res.result         = {8'h00, byte_res};
                res.flags[FLAG_Z]  = (byte_res == 8'h00);
                res.flags[FLAG_H]  = sum5[4];
                res.flags[FLAG_C]  = sum9[8];
            end
            FUNC_SUB, FUNC_SBC: begin
                res.wr_en          = 1'b1;
                res.wr_data        = byte_wr;
                res.result         = {8'h00, byte_res};
                res.flags[FLAG_Z]  = (byte_res == 8'h00);
                res.flags[FLAG_N]  = 1'b1;
                res.flags[FLAG_H]  = dif5[4];
                res.flags[FLAG_C]  = dif9[8];
            end
            FUNC_PAIR_ADD: begin
                res.wr_en          = 1'b1;
                res.wr_data        = sum17[15:0];
                res.result         = sum17[15:0];
                res.flags[FLAG_Z]  = flags_in[FLAG_Z];
                res.flags[FLAG_H]  = sum13[12];
                res.flags[FLAG_C]  = sum17[16];
            end
            FUNC_PAIR_SADD: begin
                res.wr_en          = 1'b1;
                res.wr_data        = sadd;
                res.result         = sadd;
                res.flags[FLAG_H]  = sadd_h[4];
                res.flags[FLAG_C]  = sadd_c[8];
            end
            default: begin
                res.flags = flags_in;
            end
        endcase
    end

endmodule

/* sv/cpu_add_sub_alu_with_flags_unit.sv */
// Top level of the 8-bit add/subtract ALU with zero, negative, half and carry flags.
// One item is accepted every cycle unless m_ready holds the result stage; it moves from
// the input registers to the result registers. The register file is a RAM of register
// pairs whose two read ports are sampled as the item is accepted, and the item ahead
// forwards its write into that read. Result and flags are registered as the registers
// and flags are written, so later items always see them. Reset clears the flags and the
// per-pair valid bits, so every register reads as zero at once; no clearing pass is needed.
module cpu_add_sub_alu_with_flags_unit
    import cpuas_pkg::*;
#(
    parameter int REG_COUNT = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_func,
    input  logic [2:0]  s_dst_index,
    input  logic [2:0]  s_src_index,
    input  logic        s_src_is_operand,
    input  logic [7:0]  s_operand,
    input  logic [15:0] s_pc,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_result,
    output logic [3:0]  m_flag_out,
    output logic [15:0] m_next_pc
);

    localparam int PAIR_DEPTH = (REG_COUNT + 1) / 2;
    localparam int ADDR_W     = $clog2(PAIR_DEPTH);

    logic              in_vld_reg;
    logic [2:0]        func_reg;
    logic [2:0]        dst_index_reg;
    logic [2:0]        src_index_reg;
    logic              src_is_operand_reg;
    logic [7:0]        operand_reg;
    logic [15:0]       pc_reg;
    logic [ADDR_W-1:0] waddr_reg;
    logic              dst_byp_reg;
    logic              src_byp_reg;
    logic              dst_vld_reg;
    logic              src_vld_reg;
    logic [15:0]       byp_data_reg;
    logic [PAIR_DEPTH-1:0] pvld_reg;
    logic [3:0]        flag_reg;

    logic              out_vld_reg;
    logic [15:0]       result_reg;
    logic [3:0]        flag_out_reg;
    logic [15:0]       next_pc_reg;

    logic              s_accept;
    logic              advance;
    logic              wr_en;
    logic              s_pair_op;
    logic [ADDR_W-1:0] rd_dst_addr;
    logic [ADDR_W-1:0] rd_src_addr;
    logic [15:0]       rdata_dst;
    logic [15:0]       rdata_src;
    logic [15:0]       dst_pair;
    logic [15:0]       src_pair;
    alu_res_t          alu_res;

    assign advance  = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready  = !in_vld_reg || advance;
    assign s_accept = s_valid && s_ready;
    assign wr_en    = advance && alu_res.wr_en;

    assign s_pair_op   = (s_func == FUNC_PAIR_ADD) || (s_func == FUNC_PAIR_SADD);
    assign rd_dst_addr = s_pair_op ? ADDR_W'(s_dst_index[1:0]) : ADDR_W'(s_dst_index[2:1]);
    assign rd_src_addr = s_pair_op ? ADDR_W'(s_src_index[1:0]) : ADDR_W'(s_src_index[2:1]);

    cpuas_ram #(
        .WIDTH (16),
        .DEPTH (PAIR_DEPTH)
    ) u_regs (
        .aclk    (aclk),
        .we      (wr_en),
        .waddr   (waddr_reg),
        .wdata   (alu_res.wr_data),
        .re      (s_accept),
        .raddr_a (rd_dst_addr),
        .raddr_b (rd_src_addr),
        .rdata_a (rdata_dst),
        .rdata_b (rdata_src)
    );

    assign dst_pair = dst_byp_reg ? byp_data_reg : (dst_vld_reg ? rdata_dst : 16'h0000);
    assign src_pair = src_byp_reg ? byp_data_reg : (src_vld_reg ? rdata_src : 16'h0000);

    cpuas_alu u_alu (
        .func           (func_reg),
        .dst_index      (dst_index_reg),
        .src_index      (src_index_reg),
        .src_is_operand (src_is_operand_reg),
        .operand        (operand_reg),
        .dst_pair       (dst_pair),
        .src_pair       (src_pair),
        .flags_in       (flag_reg),
        .res            (alu_res)
    );

    // Input stage: capture the item and forward the write of the item ahead.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_accept) begin
            in_vld_reg <= 1'b1;
        end else if (advance) begin
            in_vld_reg <= 1'b0;
        end
        if (s_accept) begin
            func_reg           <= s_func;
            dst_index_reg      <= s_dst_index;
            src_index_reg      <= s_src_index;
            src_is_operand_reg <= s_src_is_operand;
            operand_reg        <= s_operand;
            pc_reg             <= s_pc;
            waddr_reg          <= rd_dst_addr;
            dst_byp_reg        <= wr_en && (waddr_reg == rd_dst_addr);
            src_byp_reg        <= wr_en && (waddr_reg == rd_src_addr);
            dst_vld_reg        <= pvld_reg[rd_dst_addr];
            src_vld_reg        <= pvld_reg[rd_src_addr];
            byp_data_reg       <= alu_res.wr_data;
        end
    end

    // Architectural state: pair valid bits and flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pvld_reg <= '0;
            flag_reg <= '0;
        end else if (advance) begin
            flag_reg <= alu_res.flags;
            if (alu_res.wr_en) begin
                pvld_reg[waddr_reg] <= 1'b1;
            end
        end
    end

    // Result stage: hold until taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance) begin
            out_vld_reg <= 1'b1;
        end else if (m_ready) begin
            out_vld_reg <= 1'b0;
        end
        if (advance) begin
            result_reg   <= alu_res.result;
            flag_out_reg <= alu_res.flags;
            next_pc_reg  <= pc_reg + 16'd1;
        end
    end

    assign m_valid    = out_vld_reg;
    assign m_result   = result_reg;
    assign m_flag_out = flag_out_reg;
    assign m_next_pc  = next_pc_reg;

endmodule
